// File: hw/rtl/mfdf_pkg.sv
// Package for the mesh flood duplicate filter.
// Holds field widths, configuration register indexes and reset values.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mfdf_pkg;

    // Field widths of the mesh header and of the result word.
    localparam int NODE_W = 8;
    localparam int HOPS_W = 8;
    localparam int SEQ_W  = 8;
    localparam int TIME_W = 32;
    localparam int KEY_W  = NODE_W + SEQ_W;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MS   = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [NODE_W-1:0] OWN_ADDRESS_RESET = 8'd20;
    localparam logic [TIME_W-1:0] WINDOW_MS_RESET   = 32'd30000;

endpackage

// File: hw/rtl/mfdf_in_if.sv
// Input channel of the mesh flood duplicate filter: one received mesh header a word.
// Depends on mfdf_pkg for the field widths.
`timescale 1ns / 1ps

interface mfdf_in_if
    import mfdf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] dest_node;
    logic [HOPS_W-1:0] hops_left;
    logic [SEQ_W-1:0]  seq_low;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, source_node, dest_node, hops_left, seq_low, now_ms,
                    input ready);
    modport sink (input valid, source_node, dest_node, hops_left, seq_low, now_ms,
                  output ready);
endinterface

// File: hw/rtl/mfdf_out_if.sv
// Result channel of the mesh flood duplicate filter: one forwarding decision a word.
// Depends on mfdf_pkg for the field widths.
`timescale 1ns / 1ps

interface mfdf_out_if
    import mfdf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              forward;
    logic              duplicate;
    logic [HOPS_W-1:0] next_hops;

    modport source (output valid, forward, duplicate, next_hops, input ready);
    modport sink (input valid, forward, duplicate, next_hops, output ready);
endinterface

// File: hw/rtl/mfdf_cfg_if.sv
// Configuration write channel of the mesh flood duplicate filter.
// Depends on mfdf_pkg for the index and data widths.
`timescale 1ns / 1ps

interface mfdf_cfg_if
    import mfdf_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/mesh_flood_duplicate_filter.sv
// Top level of the mesh flood duplicate filter.
// Depends on mfdf_pkg and the interfaces mfdf_in_if, mfdf_out_if and mfdf_cfg_if.
`timescale 1ns / 1ps

// Each accepted header word forms the key {source_node, seq_low} and is checked
// against a ring of ENTRIES remembered keys and arrival times. The ring sits in a
// memory with a single read port that is walked one entry per cycle; one shared
// subtract and compare unit checks key equality and whether the entry's age (now_ms
// minus its time, modulo 2^32) is below window_ms. After a header is accepted the
// block walks the ring in ST_SCAN, then passes ST_LAST, and loads the result word in
// ST_DONE once the output register can take it; it takes no new header meanwhile.
// A result word waits in an output register, so the next header can be taken
// while it is still pending. When no recent match is found, the key and time are
// written to the next ring slot, replacing the oldest once the ring is full. Slots
// never written since reset do not match: a fill count marks which slots hold data,
// so no clearing pass is needed after reset.
// Configuration writes are taken in any cycle and are meant for idle periods.
module mesh_flood_duplicate_filter
    import mfdf_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    mfdf_in_if.sink    pkt,
    mfdf_out_if.source res,
    mfdf_cfg_if.sink   cfg
);

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = ADDR_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(ENTRIES - 1);
    localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(ENTRIES);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_LAST = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [NODE_W-1:0] own_address_reg;
    logic [TIME_W-1:0] window_ms_reg;

    // Latched header fields.
    logic [KEY_W-1:0]  key_reg;
    logic [NODE_W-1:0] dest_reg;
    logic [HOPS_W-1:0] hops_reg;
    logic [TIME_W-1:0] now_reg;

    // Scan control and ring bookkeeping.
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] write_slot_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              chk_live_reg;
    logic              dup_reg;

    // Ring memory and its registered read data.
    logic [KEY_W-1:0]  key_mem  [ENTRIES];
    logic [TIME_W-1:0] time_mem [ENTRIES];
    logic [KEY_W-1:0]  rd_key_reg;
    logic [TIME_W-1:0] rd_time_reg;

    // Output register.
    logic              out_valid_reg;
    logic              out_forward_reg;
    logic              out_duplicate_reg;
    logic [HOPS_W-1:0] out_next_hops_reg;

    logic              in_fire;
    logic              load_out;
    logic [TIME_W-1:0] age;
    logic              hit;
    logic              fwd;

    assign pkt.ready = (state_reg == ST_IDLE);
    assign in_fire   = pkt.valid && pkt.ready;
    assign cfg.ready = 1'b1;

    // Shared compare unit: one entry's key and age against the current header.
    assign age = now_reg - rd_time_reg;
    assign hit = chk_live_reg && (rd_key_reg == key_reg) && (age < window_ms_reg);

    // The result word is loaded once the scan is over and the output register is free.
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);
    assign fwd      = !dup_reg && (dest_reg != own_address_reg) && (hops_reg != '0);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_ADDR)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            own_address_reg <= OWN_ADDRESS_RESET;
            window_ms_reg   <= WINDOW_MS_RESET;
            idx_reg         <= '0;
            write_slot_reg  <= '0;
            fill_reg        <= '0;
            chk_live_reg    <= 1'b0;
            dup_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes; unknown indexes are ignored.
            if (cfg.valid)
            begin
                if (cfg.index == CFG_OWN_ADDRESS)
                begin
                    own_address_reg <= cfg.data[NODE_W-1:0];
                end
                else if (cfg.index == CFG_WINDOW_MS)
                begin
                    window_ms_reg <= cfg.data[TIME_W-1:0];
                end
            end

            // Scan address and the flag that the read data belongs to a filled slot.
            if (in_fire)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            chk_live_reg <= (state_reg == ST_SCAN) && ({1'b0, idx_reg} < fill_reg);

            // Accumulate the duplicate verdict over the walk.
            if (in_fire)
            begin
                dup_reg <= 1'b0;
            end
            else if (hit)
            begin
                dup_reg <= 1'b1;
            end

            // Ring pointer and fill count advance when a new key is stored.
            if (load_out && !dup_reg)
            begin
                write_slot_reg <= (write_slot_reg == LAST_ADDR) ? '0 : write_slot_reg + 1'b1;
                if (fill_reg != FILL_FULL)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end

            // Output word handshake.
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Header fields and result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg  <= {pkt.source_node, pkt.seq_low};
            dest_reg <= pkt.dest_node;
            hops_reg <= pkt.hops_left;
            now_reg  <= pkt.now_ms;
        end
        if (load_out)
        begin
            out_forward_reg   <= fwd;
            out_duplicate_reg <= dup_reg;
            out_next_hops_reg <= fwd ? hops_reg - 1'b1 : '0;
        end
    end

    // Ring memory: one read a cycle during the walk, one write when a key is stored.
    always_ff @(posedge clk)
    begin
        rd_key_reg  <= key_mem[idx_reg];
        rd_time_reg <= time_mem[idx_reg];
        if (load_out && !dup_reg)
        begin
            key_mem[write_slot_reg]  <= key_reg;
            time_mem[write_slot_reg] <= now_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.forward   = out_forward_reg;
    assign res.duplicate = out_duplicate_reg;
    assign res.next_hops = out_next_hops_reg;

endmodule
